// ===== src/rvn_pkg.sv =====
// Shared types and constants for the RMS vector normalizer.
// No dependencies.
package rvn_pkg;
   localparam int XW = 16;
   localparam int LENW = 7;
   localparam int EPSW = 32;
   localparam int SUMW = 40;
   localparam int INVW = 31;
   localparam int CSRW = 32;
   localparam int CSR_IDXW = 1;
   localparam logic [CSR_IDXW-1:0] CSR_VECTOR_LENGTH = 1'b0;
   localparam logic [CSR_IDXW-1:0] CSR_EPSILON = 1'b1;
   localparam logic [LENW-1:0] LEN_RESET = 7'd64;
   localparam logic [EPSW-1:0] EPS_RESET = 32'd1;

   typedef struct packed {
      logic signed [XW-1:0] x_value;
      logic signed [XW-1:0] gain_value;
   } req_type;

   typedef struct packed {
      logic signed [XW-1:0] y_value;
      logic                 last_out;
   } rsp_type;
endpackage

// ===== src/rvn_req_if.sv =====
// Input channel interface: valid/ready with x and gain payload.
// Depends on rvn_pkg.
interface rvn_req_if import rvn_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/rvn_rsp_if.sv =====
// Result channel interface: valid/ready with y and last payload.
// Depends on rvn_pkg.
interface rvn_rsp_if import rvn_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/rvn_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module rvn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/rms_vector_normalizer_top.sv =====
// RMS vector normalizer top level: buffer, accumulator, divider, root, scaler.
// Depends on rvn_pkg, rvn_req_if, rvn_rsp_if, rvn_ram.
//
// Elements are taken one per cycle into a buffer RAM while the sum of squares
// accumulates. When the vector is complete the input stalls: the mean is
// formed by a restoring divider, 2^60/(m + epsilon) by a second divider and
// the root by a 31-step bit-serial square root. The buffered elements are then
// read back, scaled and emitted, one result per cycle when the sink keeps up
// (a 3-stage read/multiply path). Throughout, one vector is in flight at a
// time; the buffer is read only at entries written for the current vector.
module rms_vector_normalizer_top import rvn_pkg::*; #(
   parameter int MAX_LEN = 64
) (
   input  logic                clock,
   input  logic                reset,
   rvn_req_if.sink             req,
   rvn_rsp_if.source           rsp,
   input  logic                csr_wr_en,
   input  logic [CSR_IDXW-1:0] csr_index,
   input  logic [CSRW-1:0]     csr_wr_data
);
   localparam int AW = $clog2(MAX_LEN);

   localparam logic [2:0] S_LOAD = 3'd0, S_DIV1 = 3'd1, S_DIV2 = 3'd2,
                          S_SQRT = 3'd3, S_EMIT = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [LENW-1:0] len_ff;
   logic [EPSW-1:0] eps_ff;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [LENW-1:0] cnt_ff, cnt_in;

   // shared restoring divider / square root registers
   logic [63:0]     num_ff, num_in;       // dividend / radicand shift
   logic [63:0]     rem_ff, rem_in;
   logic [63:0]     quo_ff, quo_in;
   logic [32:0]     den_ff, den_in;
   logic [6:0]      step_ff, step_in;
   logic [INVW-1:0] inv_ff, inv_in;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
         eps_ff <= EPS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VECTOR_LENGTH: len_ff <= csr_wr_data[LENW-1:0];
            CSR_EPSILON:       eps_ff <= csr_wr_data[EPSW-1:0];
            default: ;
         endcase
      end
   end

   logic [LENW-1:0] eff_len;
   always_comb begin
      eff_len = len_ff;
      if (len_ff == '0) eff_len = LENW'(1);
      if (len_ff > LENW'(MAX_LEN)) eff_len = LENW'(MAX_LEN);
   end

   logic acc;
   logic signed [31:0] sq;
   logic [LENW-1:0] cnt_next;
   assign req.ready = (state_ff == S_LOAD);
   assign acc = req.valid && req.ready;
   assign sq = req.payload.x_value * req.payload.x_value;
   assign cnt_next = cnt_ff + LENW'(1);

   // emit pipeline
   logic [LENW-1:0] rd_ptr_ff, rd_ptr_in;
   logic            v1_ff, v1_in, l1_ff, l1_in;
   logic            v2_ff, v2_in, l2_ff, l2_in;
   logic signed [31:0] p2_ff;
   logic            ov_ff, ov_in;
   rsp_type         od_ff, od_in;
   logic [XW-1:0]   x_rd, g_rd;
   logic            adv;
   logic            issue;
   logic [AW-1:0]   rd_addr;

   assign adv   = !ov_ff || rsp.ready;
   assign issue = (state_ff == S_EMIT) && (rd_ptr_ff < cnt_ff) && adv;
   // on a stall, re-read the entry held in stage 1 so its data is kept
   assign rd_addr = (adv || !v1_ff) ? rd_ptr_ff[AW-1:0] : rd_ptr_ff[AW-1:0] - AW'(1);

   rvn_ram #(.WIDTH(XW), .DEPTH(MAX_LEN)) u_xram (
      .clock(clock), .wr_en(acc), .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(req.payload.x_value), .rd_addr(rd_addr), .rd_data(x_rd));
   rvn_ram #(.WIDTH(XW), .DEPTH(MAX_LEN)) u_gram (
      .clock(clock), .wr_en(acc), .wr_addr(cnt_ff[AW-1:0]),
      .wr_data(req.payload.gain_value), .rd_addr(rd_addr), .rd_data(g_rd));

   // stage 3 arithmetic: |p| * inv, round, saturate
   logic [31:0] mag;
   logic [62:0] prod;
   logic [32:0] r;
   logic        neg;
   always_comb begin
      neg  = p2_ff[31];
      mag  = neg ? 32'(-p2_ff) : 32'(p2_ff);
      prod = 63'(mag) * 63'(inv_ff);
      r    = 33'((prod + 63'(64'd1 << 29)) >> 30);
      od_in = od_ff;
      if (v2_ff && adv) begin
         if (neg) od_in.y_value = (r > 33'd32768) ? -16'sd32768 : 16'(-r);
         else     od_in.y_value = (r > 33'd32767) ? 16'sd32767 : 16'(r);
         od_in.last_out = l2_ff;
      end
   end

   logic [63:0] trial;
   logic [63:0] sq_trial;
   always_comb begin
      state_in = state_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      step_in = step_ff; inv_in = inv_ff; rd_ptr_in = rd_ptr_ff;
      trial = '0; sq_trial = '0;
      v1_in = v1_ff; l1_in = l1_ff; v2_in = v2_ff; l2_in = l2_ff;
      ov_in = ov_ff;
      unique case (state_ff)
         S_LOAD: if (acc) begin
            sum_in = sum_ff + SUMW'(unsigned'(sq));
            cnt_in = cnt_next;
            if (cnt_next >= eff_len) begin
               state_in = S_DIV1;
               num_in = 64'(sum_in);
               rem_in = '0; quo_in = '0;
               den_in = 33'(cnt_next);
               step_in = 7'd40;
            end
         end
         S_DIV1: begin
            trial = {rem_ff[62:0], num_ff[SUMW-1]};
            num_in = num_ff << 1;
            if (trial >= 64'(den_ff)) begin
               rem_in = trial - 64'(den_ff); quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial; quo_in = {quo_ff[62:0], 1'b0};
            end
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) begin
               state_in = S_DIV2;
               den_in = 33'(quo_in) + 33'(eps_ff);
               if (den_in == '0) den_in = 33'd1;
               num_in = 64'd1 << 60;
               rem_in = '0; quo_in = '0;
               step_in = 7'd61;
            end
         end
         S_DIV2: begin
            trial = {rem_ff[62:0], num_ff[60]};
            num_in = num_ff << 1;
            if (trial >= 64'(den_ff)) begin
               rem_in = trial - 64'(den_ff); quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = trial; quo_in = {quo_ff[62:0], 1'b0};
            end
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) begin
               state_in = S_SQRT;
               num_in = quo_in;     // radicand
               rem_in = '0; quo_in = '0;
               step_in = 7'd31;
            end
         end
         S_SQRT: begin
            // two radicand bits per step
            sq_trial = {rem_ff[61:0], num_ff[61:60]};
            trial = {quo_ff[61:0], 2'b01};
            num_in = num_ff << 2;
            if (sq_trial >= trial) begin
               rem_in = sq_trial - trial; quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = sq_trial; quo_in = {quo_ff[62:0], 1'b0};
            end
            step_in = step_ff - 7'd1;
            if (step_ff == 7'd1) begin
               state_in = S_EMIT;
               inv_in = INVW'(quo_in);
               rd_ptr_in = '0;
            end
         end
         S_EMIT: begin
            if (issue) rd_ptr_in = rd_ptr_ff + LENW'(1);
            if (rd_ptr_ff == cnt_ff && !v1_ff && !v2_ff && !ov_ff) begin
               state_in = S_LOAD; sum_in = '0; cnt_in = '0;
            end
         end
         default: state_in = S_LOAD;
      endcase
      if (adv) begin
         v1_in = issue;
         l1_in = (rd_ptr_ff + LENW'(1) == cnt_ff);
         v2_in = v1_ff;
         l2_in = l1_ff;
         ov_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) p2_ff <= $signed(x_rd) * $signed(g_rd);
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      inv_ff <= inv_in; od_ff <= od_in; l1_ff <= l1_in; l2_ff <= l2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; sum_ff <= '0; cnt_ff <= '0; step_ff <= '0;
         rd_ptr_ff <= '0; v1_ff <= 1'b0; v2_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
         step_ff <= step_in; rd_ptr_ff <= rd_ptr_in;
         v1_ff <= v1_in; v2_ff <= v2_in; ov_ff <= ov_in;
      end
   end

   assign rsp.valid   = ov_ff;
   assign rsp.payload = od_ff;
endmodule
